// File: rtl/mrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_pkg
// shared types, constants and the crc helper of the modbus response decoder
// ----------------------------------------------------------------------------
package mrd_pkg;

    localparam int CHANNELS      = 12;
    localparam int TEMP_CHANNELS = 4;
    localparam int AVERAGE_AFTER = 10;

    localparam int FRAME_DATA    = 2 * CHANNELS;
    localparam int IDX_W         = $clog2(CHANNELS);
    localparam int TJ_W          = (TEMP_CHANNELS > 1) ? $clog2(TEMP_CHANNELS) : 1;
    localparam int TEMP_FIRST    = 4;
    localparam int DIGITAL_COUNT = 4;
    localparam int SUM_W         = 21;
    localparam int CNT_W         = 4;
    localparam int DIVISOR       = AVERAGE_AFTER - 1;
    localparam int DIV_STEPS     = 1;
    localparam int DIVC_W        = $clog2(DIV_STEPS + 1);

    // reciprocal of the sample count, rounded up, exact for every trimmed sum
    localparam int RECIP_SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W       = SUM_W + 1;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int QUO_W         = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] DIGITAL_MASK = 16'h0F80;

    localparam logic [1:0] RES_VALUE   = 2'd0;
    localparam logic [1:0] RES_CRC_ERR = 2'd1;
    localparam logic [1:0] RES_LEN_ERR = 2'd2;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_FUNC     = 1'b1;

    typedef enum logic [3:0] {
        ST_ADDR,
        ST_FUNC,
        ST_LEN,
        ST_DATA,
        ST_CRCL,
        ST_CRCH,
        ST_READ,
        ST_CALC,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic start;
        logic crc_upd;
        logic len_load;
        logic data_take;
        logic crcl_load;
        logic crch_take;
        logic emit_start;
        logic calc_out;
        logic div_start;
        logic avg_out;
    } mrd_cmd_t;

    typedef struct packed {
        logic is_addr;
        logic is_func;
        logic is_zero;
        logic data_last;
        logic crc_ok;
        logic len_ok;
        logic need_avg;
        logic div_done;
        logic idx_last;
        logic out_free;
    } mrd_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: rtl/mrd_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_rx_if
// received byte channel: valid, ready and one serial byte
// ----------------------------------------------------------------------------
interface mrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/mrd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_res_if
// result channel: valid, ready and one decoded channel result
// ----------------------------------------------------------------------------
interface mrd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  channel;
    logic [15:0] value;
    logic        average_valid;
    logic [15:0] temp_average;
    logic        last;

    modport source (output valid, output status, output channel, output value,
                    output average_valid, output temp_average, output last, input ready);
    modport sink (input valid, input status, input channel, input value,
                  input average_valid, input temp_average, input last, output ready);
endinterface

// File: rtl/mrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_ctrl
// frame parser and result sequencer state machine
// ----------------------------------------------------------------------------
module mrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mrd_pkg::mrd_stat_t stat,
    output mrd_pkg::mrd_cmd_t  cmd
);
    import mrd_pkg::*;

    state_t state_reg, state_next;
    logic   take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ADDR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_ADDR, ST_FUNC, ST_LEN, ST_DATA, ST_CRCL:
                in_ready = 1'b1;
            ST_CRCH:
                in_ready = stat.out_free;
            default:
                in_ready = 1'b0;
        endcase
        take = in_valid && in_ready;

        case (state_reg)
            ST_ADDR:
            begin
                if (take && stat.is_addr)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_FUNC;
                end
            end
            ST_FUNC:
            begin
                if (take)
                begin
                    if (stat.is_func)
                    begin
                        cmd.crc_upd = 1'b1;
                        state_next  = ST_LEN;
                    end
                    else if (stat.is_addr)
                        cmd.start = 1'b1;
                    else
                        state_next = ST_ADDR;
                end
            end
            ST_LEN:
            begin
                if (take)
                begin
                    cmd.crc_upd  = 1'b1;
                    cmd.len_load = 1'b1;
                    state_next   = stat.is_zero ? ST_CRCL : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (take)
                begin
                    cmd.crc_upd   = 1'b1;
                    cmd.data_take = 1'b1;
                    if (stat.data_last)
                        state_next = ST_CRCL;
                end
            end
            ST_CRCL:
            begin
                if (take)
                begin
                    cmd.crcl_load = 1'b1;
                    state_next    = ST_CRCH;
                end
            end
            ST_CRCH:
            begin
                if (take)
                begin
                    cmd.crch_take = 1'b1;
                    if (stat.crc_ok && stat.len_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_READ;
                    end
                    else
                        state_next = ST_ADDR;
                end
            end
            ST_READ:
                state_next = ST_CALC;
            ST_CALC:
            begin
                if (stat.out_free)
                begin
                    if (stat.need_avg)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.calc_out = 1'b1;
                        state_next   = stat.idx_last ? ST_ADDR : ST_READ;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done && stat.out_free)
                begin
                    cmd.avg_out = 1'b1;
                    state_next  = stat.idx_last ? ST_ADDR : ST_READ;
                end
            end
            default:
                state_next = ST_ADDR;
        endcase
    end

    // good frame always enters the result sequence
    a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRCH && take && stat.crc_ok && stat.len_ok) |=> state_reg == ST_READ)
        else $error("good frame did not start results");

    // divider is never abandoned before it finishes
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !stat.div_done) |=> state_reg == ST_DIV)
        else $error("left divide early");

    // no byte is taken while results are being produced
    a_no_rx_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CALC || state_reg == ST_DIV) |-> !in_ready)
        else $error("byte taken during result sequence");

endmodule

// File: rtl/mrd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_datapath
// crc, frame word store, temperature statistics, divider and output register
// ----------------------------------------------------------------------------
module mrd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  mrd_pkg::mrd_cmd_t  cmd,
    output mrd_pkg::mrd_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [3:0]         out_channel,
    output logic [15:0]        out_value,
    output logic               out_average_valid,
    output logic [15:0]        out_temp_average,
    output logic               out_last
);
    import mrd_pkg::*;

    logic [7:0]  dev_addr_reg, func_reg;
    logic [15:0] crc_reg;
    logic [7:0]  len_reg, cnt_reg, crcl_reg, hi_reg;
    logic [15:0] mem [CHANNELS];
    logic [15:0] rdata_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [SUM_W-1:0] sum_reg [TEMP_CHANNELS];
    logic [CNT_W-1:0] count_reg [TEMP_CHANNELS];
    logic [15:0]      max_reg [TEMP_CHANNELS];
    logic [15:0]      min_reg [TEMP_CHANNELS];
    logic [15:0]      avg_reg [TEMP_CHANNELS];

    logic [SUM_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DIVC_W-1:0] divc_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [3:0]        channel_reg;
    logic [15:0]       value_reg, tavg_reg;
    logic              avalid_reg, last_reg;

    logic [7:0]        cnt_inc;
    logic [IDX_W-1:0]  j_full;
    logic [TJ_W-1:0]   j;
    logic              is_temp, is_dig;
    logic [SUM_W-1:0]  sum_add;
    logic [15:0]       max_n, min_n, dig_v, avg_sat;
    logic [CNT_W:0]    cnt1;
    logic signed [SUM_W+1:0] num;
    logic [PROD_W-1:0] prod;
    logic              out_free, out_write;

    assign cnt_inc = cnt_reg + 8'd1;
    assign j_full  = idx_reg - IDX_W'(TEMP_FIRST);
    assign j       = j_full[TJ_W-1:0];
    assign is_temp = (idx_reg >= IDX_W'(TEMP_FIRST)) &&
                     (idx_reg < IDX_W'(TEMP_FIRST + TEMP_CHANNELS));
    assign is_dig  = idx_reg < IDX_W'(DIGITAL_COUNT);
    assign dig_v   = ((rdata_reg & DIGITAL_MASK) == DIGITAL_MASK) ? 16'd1 : 16'd0;
    assign sum_add = sum_reg[j] + SUM_W'(rdata_reg);
    assign max_n   = (rdata_reg > max_reg[j]) ? rdata_reg : max_reg[j];
    assign min_n   = (rdata_reg < min_reg[j]) ? rdata_reg : min_reg[j];
    assign cnt1    = {1'b0, count_reg[j]} + (CNT_W+1)'(1);
    assign num     = $signed({2'b00, sum_add}) - $signed({(SUM_W-14)'(0), max_n})
                     - $signed({(SUM_W-14)'(0), min_n});
    assign prod    = {{RECIP_W{1'b0}}, dvd_reg} * {{SUM_W{1'b0}}, RECIP_K};
    assign avg_sat = (quo_reg > QUO_W'(16'hFFFF)) ? 16'hFFFF : quo_reg[15:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign out_write = cmd.calc_out || cmd.avg_out;

    always_comb
    begin
        stat.is_addr   = rx_byte == dev_addr_reg;
        stat.is_func   = rx_byte == func_reg;
        stat.is_zero   = rx_byte == 8'd0;
        stat.data_last = cnt_inc >= len_reg;
        stat.crc_ok    = {rx_byte, crcl_reg} == crc_reg;
        stat.len_ok    = len_reg == 8'(FRAME_DATA);
        stat.need_avg  = is_temp && (cnt1 > (CNT_W+1)'(AVERAGE_AFTER));
        stat.div_done  = divc_reg == '0;
        stat.idx_last  = idx_reg == IDX_W'(CHANNELS - 1);
        stat.out_free  = out_free;
    end

    // configuration and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= 8'd1;
            func_reg      <= 8'd3;
            crc_reg       <= CRC_INIT;
            len_reg       <= '0;
            cnt_reg       <= '0;
            crcl_reg      <= '0;
            idx_reg       <= '0;
            divc_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TEMP_CHANNELS; t++)
            begin
                sum_reg[t]   <= '0;
                count_reg[t] <= '0;
                max_reg[t]   <= '0;
                min_reg[t]   <= '0;
                avg_reg[t]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEV_ADDR: dev_addr_reg <= cfg_data;
                    CFG_FUNC:     func_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.start)
                crc_reg <= crc_byte(CRC_INIT, rx_byte);
            else if (cmd.crc_upd)
                crc_reg <= crc_byte(crc_reg, rx_byte);
            if (cmd.len_load)
            begin
                len_reg <= rx_byte;
                cnt_reg <= '0;
            end
            if (cmd.data_take)
                cnt_reg <= cnt_inc;
            if (cmd.crcl_load)
                crcl_reg <= rx_byte;
            if (cmd.emit_start)
                idx_reg <= '0;
            else if (out_write)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.div_start)
                divc_reg <= DIVC_W'(DIV_STEPS);
            else if (divc_reg != '0)
                divc_reg <= divc_reg - DIVC_W'(1);

            if (cmd.calc_out && is_temp)
            begin
                sum_reg[j]   <= sum_add;
                max_reg[j]   <= max_n;
                min_reg[j]   <= min_n;
                count_reg[j] <= cnt1[CNT_W-1:0];
            end
            if (cmd.avg_out)
            begin
                sum_reg[j]   <= '0;
                count_reg[j] <= '0;
                max_reg[j]   <= avg_sat;
                min_reg[j]   <= avg_sat;
                avg_reg[j]   <= avg_sat;
            end

            if (out_write || (cmd.crch_take && !(stat.crc_ok && stat.len_ok)))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame word store, high byte held until its low byte arrives
    always_ff @(posedge clk)
    begin
        if (cmd.data_take && (cnt_reg < 8'(FRAME_DATA)))
        begin
            if (!cnt_reg[0])
                hi_reg <= rx_byte;
            else
                mem[cnt_reg[IDX_W:1]] <= {hi_reg, rx_byte};
        end
        rdata_reg <= mem[idx_reg];
    end

    // divide by the constant sample count through its reciprocal:
    // trimmed sum registered first, quotient in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            dvd_reg <= (num > 0) ? num[SUM_W-1:0] : '0;
        else if (divc_reg != '0)
            quo_reg <= prod[PROD_W-1:RECIP_SHIFT];
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.crch_take && !(stat.crc_ok && stat.len_ok))
        begin
            status_reg  <= stat.crc_ok ? RES_LEN_ERR : RES_CRC_ERR;
            channel_reg <= '0;
            value_reg   <= '0;
            avalid_reg  <= 1'b0;
            tavg_reg    <= '0;
            last_reg    <= 1'b1;
        end
        else if (out_write)
        begin
            status_reg  <= RES_VALUE;
            channel_reg <= idx_reg[3:0];
            value_reg   <= is_dig ? dig_v : rdata_reg;
            avalid_reg  <= cmd.avg_out;
            tavg_reg    <= cmd.avg_out ? avg_sat : (is_temp ? avg_reg[j] : 16'd0);
            last_reg    <= stat.idx_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = status_reg;
    assign out_channel       = channel_reg;
    assign out_value         = value_reg;
    assign out_average_valid = avalid_reg;
    assign out_temp_average  = tavg_reg;
    assign out_last          = last_reg;

endmodule

// File: rtl/modbus_io_response_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_io_response_decoder
// parses modbus rtu responses of a 12-channel i/o module into channel results
// ----------------------------------------------------------------------------
// usage:
//   rx carries received serial bytes, one per transfer; result carries decoded
//   channel results. cfg_we/cfg_index/cfg_data write the expected device
//   address (index 0) and function code (index 1); write them only while idle.
//   every byte of a frame is taken when valid; the final crc byte of a good
//   frame starts a result sequence that, for each channel, reads the word from
//   the frame store, then writes it to the output register.
//   a temperature channel that closes its averaging window adds a divide:
//   the trimmed sum is registered, then the reciprocal multiply result.
//   crc and length errors give a single result at once. rx is not ready
//   during a result sequence, and the final crc byte waits while a result is
//   still held in the output register.
//   if the receiver stalls, the result stays in the output register and the
//   sequencer waits. reset returns the parser to address hunt, presets crc,
//   clears counters and temperature statistics, and loads address 1, function 3.
// ----------------------------------------------------------------------------
module modbus_io_response_decoder (
    input  logic        clk,
    input  logic        rst_n,
    mrd_rx_if.sink      rx,
    mrd_res_if.source   result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import mrd_pkg::*;

    mrd_cmd_t  cmd;
    mrd_stat_t stat;

    // parser and sequencer
    mrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // crc, store, statistics and output register
    mrd_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_byte           (rx.rx_byte),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .stat              (stat),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .out_status        (result.status),
        .out_channel       (result.channel),
        .out_value         (result.value),
        .out_average_valid (result.average_valid),
        .out_temp_average  (result.temp_average),
        .out_last          (result.last)
    );

endmodule
